### rtl/uipr_pkg.sv
package uipr_pkg;

  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_NACK    = 3'd1;
  localparam logic [2:0] KIND_ERASE   = 3'd2;
  localparam logic [2:0] KIND_WORD    = 3'd3;
  localparam logic [2:0] KIND_VERSION = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;
  localparam logic [2:0] KIND_ABORT   = 3'd6;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_VER   = 3'd1;
  localparam logic [2:0] ACT_START = 3'd2;
  localparam logic [2:0] ACT_NACK  = 3'd3;
  localparam logic [2:0] ACT_CHUNK = 3'd4;
  localparam logic [2:0] ACT_EMPTY = 3'd5;
  localparam logic [2:0] ACT_END   = 3'd6;
  localparam logic [2:0] ACT_ABORT = 3'd7;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_HALT = 2'd2;

  localparam logic [2:0] REG_START   = 3'd0;
  localparam logic [2:0] REG_CHUNK   = 3'd1;
  localparam logic [2:0] REG_END     = 3'd2;
  localparam logic [2:0] REG_ABORT   = 3'd3;
  localparam logic [2:0] REG_VERSION = 3'd4;
  localparam logic [2:0] REG_BANK    = 3'd5;

  localparam int HEADER_LEN = 5;
  localparam int START_LEN  = 7;
  localparam int STORE_EXTRA = 64;

  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic       last;
    logic       rd;
    logic       cap;
    logic       next_word;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       busy;
    logic       k3;
    logic       words_done;
  } status_t;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  chunk_code;
    logic [7:0]  end_code;
    logic [7:0]  abort_code;
    logic [7:0]  version_code;
    logic [31:0] bank_base;
  } cfg_t;

endpackage

### rtl/uipr_ram.sv
module uipr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/uipr_ctrl.sv
module uipr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  uipr_pkg::status_t   status,
  output logic                in_ready,
  output uipr_pkg::cmd_t      cmd
);

  localparam logic [3:0] ST_IN    = 4'd0;
  localparam logic [3:0] ST_VER   = 4'd1;
  localparam logic [3:0] ST_ERASE = 4'd2;
  localparam logic [3:0] ST_ACK   = 4'd3;
  localparam logic [3:0] ST_NACK  = 4'd4;
  localparam logic [3:0] ST_CACK  = 4'd5;
  localparam logic [3:0] ST_RD    = 4'd6;
  localparam logic [3:0] ST_CAP   = 4'd7;
  localparam logic [3:0] ST_WORD  = 4'd8;
  localparam logic [3:0] ST_END   = 4'd9;
  localparam logic [3:0] ST_ABORT = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IN);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IN: begin
        if (accept) begin
          case (status.action)
            uipr_pkg::ACT_VER:   state_next = ST_VER;
            uipr_pkg::ACT_START: state_next = ST_ERASE;
            uipr_pkg::ACT_NACK:  state_next = ST_NACK;
            uipr_pkg::ACT_CHUNK: state_next = ST_RD;
            uipr_pkg::ACT_EMPTY: state_next = ST_CACK;
            uipr_pkg::ACT_END:   state_next = ST_END;
            uipr_pkg::ACT_ABORT: state_next = ST_ABORT;
            default:             state_next = ST_IN;
          endcase
        end
      end
      ST_VER, ST_NACK, ST_END, ST_ABORT, ST_ACK: begin
        if (!status.busy) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          case (state)
            ST_VER:  cmd.kind = uipr_pkg::KIND_VERSION;
            ST_NACK: cmd.kind = uipr_pkg::KIND_NACK;
            ST_END:  cmd.kind = uipr_pkg::KIND_END;
            ST_ABORT: cmd.kind = uipr_pkg::KIND_ABORT;
            default: cmd.kind = uipr_pkg::KIND_ACK;
          endcase
          state_next = ST_IN;
        end
      end
      ST_ERASE: begin
        if (!status.busy) begin
          cmd.emit = 1'b1;
          cmd.kind = uipr_pkg::KIND_ERASE;
          state_next = ST_ACK;
        end
      end
      ST_CACK: begin
        if (!status.busy) begin
          cmd.emit = 1'b1;
          cmd.kind = uipr_pkg::KIND_ACK;
          cmd.last = 1'b1;
          cmd.commit = 1'b1;
          state_next = ST_IN;
        end
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        state_next = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap = 1'b1;
        state_next = status.k3 ? ST_WORD : ST_RD;
      end
      ST_WORD: begin
        if (!status.busy) begin
          cmd.emit = 1'b1;
          cmd.kind = uipr_pkg::KIND_WORD;
          cmd.next_word = 1'b1;
          state_next = status.words_done ? ST_CACK : ST_RD;
        end
      end
      default: state_next = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

  a_accept_only_in: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == ST_IN)
    else $error("item accepted while a packet is being worked on");

  a_cap_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.cap |-> $past(cmd.rd))
    else $error("store byte captured without a read the cycle before");

  a_commit_acks: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> cmd.emit && cmd.kind == uipr_pkg::KIND_ACK && cmd.last)
    else $error("chunk committed without its acknowledge");

endmodule

### rtl/uipr_dp.sv
module uipr_dp #(
  parameter int STORE = 192
) (
  input  logic                clk,
  input  logic                rst,
  input  uipr_pkg::cfg_t      cfg,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  uipr_pkg::cmd_t      cmd,
  output uipr_pkg::status_t   status,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [103:0]        m_tdata,
  output logic                m_tlast
);

  localparam int CW = $clog2(STORE + 1);
  localparam int AW = $clog2(STORE);

  logic [1:0]    mode;
  logic [CW-1:0] fill;
  logic [7:0]    xacc;
  logic [7:0]    hdr [5];
  logic [15:0]   nseq;
  logic [31:0]   wp;
  logic [31:0]   total;
  logic [CW-1:0] dlen;
  logic [CW-1:0] pos;
  logic [1:0]    k;
  logic [31:0]   wbuf;

  logic [2:0]    o_kind;
  logic [31:0]   o_addr;
  logic [31:0]   o_word;
  logic [31:0]   o_count;
  logic          o_last;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [CW-1:0] fill_n;
  logic [7:0]    xor_n;
  logic [7:0]    h_n [5];
  logic [15:0]   seq_n;
  logic [15:0]   len_n;
  logic          is_start;
  logic          chunk_zone;
  logic          chunk_done;
  logic          end_hit;
  logic          abort_hit;
  logic [2:0]    action;
  logic [CW:0]   idx;
  logic [CW:0]   rd_idx;
  logic [CW:0]   pos4;

  always_comb begin
    fill_n = fill + CW'(1);
    xor_n = xacc ^ rx_byte;
    for (int i = 0; i < 5; i++) begin
      h_n[i] = (fill == CW'(i)) ? rx_byte : hdr[i];
    end
    seq_n = {h_n[2], h_n[1]};
    len_n = {h_n[4], h_n[3]};
    is_start = (h_n[0] == cfg.start_code) && (fill_n == CW'(uipr_pkg::START_LEN));
    chunk_zone = !is_start && (h_n[0] == cfg.chunk_code) &&
                 (fill_n >= CW'(uipr_pkg::HEADER_LEN));
    chunk_done = chunk_zone && ({1'b0, len_n} + 17'd6 == 17'(fill_n));
    end_hit = !is_start && !chunk_zone && (rx_byte == cfg.end_code) && (fill_n <= CW'(2));
    abort_hit = !is_start && !chunk_zone && !end_hit && (rx_byte == cfg.abort_code);
    action = uipr_pkg::ACT_NONE;
    case (mode)
      uipr_pkg::MODE_IDLE: begin
        if (rx_byte != cfg.start_code && rx_byte == cfg.version_code) begin
          action = uipr_pkg::ACT_VER;
        end
      end
      uipr_pkg::MODE_RECV: begin
        if (is_start) begin
          action = (xor_n == 8'd0) ? uipr_pkg::ACT_START : uipr_pkg::ACT_NACK;
        end else if (chunk_done) begin
          if (xor_n == 8'd0 && seq_n == nseq) begin
            action = (len_n == 16'd0) ? uipr_pkg::ACT_EMPTY : uipr_pkg::ACT_CHUNK;
          end else begin
            action = uipr_pkg::ACT_NACK;
          end
        end else if (end_hit) begin
          action = uipr_pkg::ACT_END;
        end else if (abort_hit) begin
          action = uipr_pkg::ACT_ABORT;
        end
      end
      default: action = uipr_pkg::ACT_NONE;
    endcase
  end

  assign idx    = {1'b0, pos} + {{(CW - 1){1'b0}}, k};
  assign rd_idx = idx + (CW + 1)'(uipr_pkg::HEADER_LEN);
  assign pos4   = {1'b0, pos} + (CW + 1)'(4);

  assign ram_we = accept && ((mode == uipr_pkg::MODE_RECV) ||
                  (mode == uipr_pkg::MODE_IDLE && rx_byte == cfg.start_code));
  assign ram_waddr = (mode == uipr_pkg::MODE_RECV) ? fill[AW-1:0] : '0;
  assign ram_raddr = rd_idx[AW-1:0];

  uipr_ram #(.WIDTH(8), .DEPTH(STORE)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status.action     = action;
  assign status.busy       = m_tvalid && !m_tready;
  assign status.k3         = (k == 2'd3);
  assign status.words_done = (pos4 >= {1'b0, dlen});

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= uipr_pkg::MODE_IDLE;
      fill  <= '0;
      xacc  <= '0;
      nseq  <= '0;
      wp    <= '0;
      total <= '0;
    end else begin
      if (accept) begin
        case (mode)
          uipr_pkg::MODE_IDLE: begin
            if (rx_byte == cfg.start_code) begin
              mode <= uipr_pkg::MODE_RECV;
              fill <= CW'(1);
              xacc <= rx_byte;
            end
          end
          uipr_pkg::MODE_RECV: begin
            if (is_start || chunk_done) begin
              fill <= '0;
              xacc <= '0;
              if (action == uipr_pkg::ACT_START) begin
                wp    <= cfg.bank_base;
                total <= '0;
                nseq  <= '0;
              end
            end else if (end_hit) begin
              mode <= uipr_pkg::MODE_HALT;
              fill <= '0;
              xacc <= '0;
            end else if (abort_hit) begin
              mode <= uipr_pkg::MODE_IDLE;
              fill <= '0;
              xacc <= '0;
            end else if (fill_n == CW'(STORE)) begin
              fill <= '0;
              xacc <= '0;
            end else begin
              fill <= fill_n;
              xacc <= xor_n;
            end
          end
          default: mode <= mode;
        endcase
      end
      if (cmd.commit) begin
        wp    <= wp + 32'(dlen);
        total <= total + 32'(dlen);
        nseq  <= nseq + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (mode == uipr_pkg::MODE_IDLE) begin
        hdr[0] <= rx_byte;
      end else begin
        for (int i = 0; i < 5; i++) begin
          hdr[i] <= h_n[i];
        end
      end
      if (action == uipr_pkg::ACT_CHUNK || action == uipr_pkg::ACT_EMPTY) begin
        dlen <= len_n[CW-1:0];
        pos  <= '0;
        k    <= '0;
      end
    end
    if (cmd.cap) begin
      wbuf[8*k +: 8] <= (idx < {1'b0, dlen}) ? ram_rdata : 8'hFF;
      k <= k + 2'd1;
    end
    if (cmd.next_word) begin
      pos <= pos4[CW-1:0];
      k   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_kind  <= cmd.kind;
      o_last  <= cmd.last;
      o_addr  <= (cmd.kind == uipr_pkg::KIND_ERASE) ? cfg.bank_base :
                 (cmd.kind == uipr_pkg::KIND_WORD) ? wp + 32'(pos) : 32'd0;
      o_word  <= (cmd.kind == uipr_pkg::KIND_WORD) ? wbuf : 32'd0;
      o_count <= (cmd.kind == uipr_pkg::KIND_END) ? total : 32'd0;
    end
  end

  assign m_tdata = {5'd0, o_count, o_word, o_addr, o_kind};
  assign m_tlast = o_last;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(m_tvalid && !m_tready))
    else $error("result register overwritten before it was taken");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill < CW'(STORE))
    else $error("fill count outside the packet store");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> nseq == $past(nseq) + 16'd1)
    else $error("sequence number did not advance on commit");

endmodule

### rtl/update_image_packet_receiver_top.sv
// Firmware-update packet receiver: one serial byte per input item, results as
// erase, flash-word, ack/nack, version, end and abort items. An accepted
// chunk is read back through the single-byte read port of the packet store:
// each payload byte is read and then captured, and each group of four bytes
// is then emitted as one word. Every result waits while the output register
// is still full. No new byte is taken until the last result of the current
// one has been loaded into the output register.
module update_image_packet_receiver_top #(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // kind[2:0], address, word, byte_count, zero fill
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int STORE = MAX_PAYLOAD + uipr_pkg::STORE_EXTRA;

  uipr_pkg::cfg_t    cfg;
  uipr_pkg::cmd_t    cmd;
  uipr_pkg::status_t status;
  logic              accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code   <= 8'hAA;
      cfg.chunk_code   <= 8'hBB;
      cfg.end_code     <= 8'hCC;
      cfg.abort_code   <= 8'hDD;
      cfg.version_code <= 8'hEE;
      cfg.bank_base    <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        uipr_pkg::REG_START:   cfg.start_code   <= cfg_data[7:0];
        uipr_pkg::REG_CHUNK:   cfg.chunk_code   <= cfg_data[7:0];
        uipr_pkg::REG_END:     cfg.end_code     <= cfg_data[7:0];
        uipr_pkg::REG_ABORT:   cfg.abort_code   <= cfg_data[7:0];
        uipr_pkg::REG_VERSION: cfg.version_code <= cfg_data[7:0];
        uipr_pkg::REG_BANK:    cfg.bank_base    <= cfg_data;
        default: ;
      endcase
    end
  end

  uipr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  uipr_dp #(.STORE(STORE)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .rx_byte  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
